[rtl/otse_pkg.sv]
// package: table geometry, transaction types, result codes and state encodings
package otse_pkg;

  localparam int NUM_TICKERS       = 8;
  localparam int ORDERS_PER_TICKER = 1024;
  localparam int TABLE_SIZE        = NUM_TICKERS * ORDERS_PER_TICKER;
  localparam int ADDR_W            = $clog2(TABLE_SIZE);
  localparam int SLOT_W            = $clog2(ORDERS_PER_TICKER);

  // item function
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_SCAN   = 1'b1;

  // update types
  localparam logic [1:0] UPD_ADD    = 2'd0;
  localparam logic [1:0] UPD_MODIFY = 2'd1;
  localparam logic [1:0] UPD_CANCEL = 2'd2;
  localparam logic [1:0] UPD_OTHER  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_ACK   = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_CLEAR = 3'd2;
  localparam logic [2:0] KIND_ENTRY = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  // result status
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_EXISTS  = 3'd1;
  localparam logic [2:0] STAT_MISSING = 3'd2;
  localparam logic [2:0] STAT_SIDE    = 3'd3;
  localparam logic [2:0] STAT_GAP     = 3'd4;
  localparam logic [2:0] STAT_BUSY    = 3'd5;

  typedef struct packed {
    logic               func;
    logic [1:0]         update_type;
    logic [31:0]        seq_num;
    logic [2:0]         ticker;
    logic [9:0]         order_id;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        priority_req;
  } req_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         status;
    logic [13:0]        snap_index;
    logic [31:0]        last_seq;
    logic [2:0]         out_ticker;
    logic [9:0]         out_order_id;
    logic               out_side;
    logic signed [31:0] out_price;
    logic [31:0]        out_qty;
    logic [31:0]        out_priority;
  } rsp_t;

  // one table slot as stored in memory
  typedef struct packed {
    logic               valid;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        priority_val;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_CLEAR  = 4'b0010,
    PH_ORDERS = 4'b0100,
    PH_END    = 4'b1000
  } phase_t;

endpackage

[rtl/otse_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module otse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/order_table_snapshot_engine_core.sv]
// order table with add/modify/cancel updates and a step-wise snapshot walk
// a transaction and its table read are registered; its result then enters the output register
// no new transaction is taken before its lookup ends, due to the read-modify-write of the table ram
// a new transaction is taken while an earlier result still waits on rsp_stall
// reset: synchronous; a clearing pass then zeroes all TABLE_SIZE (8192) slots of the
// table, during which no transaction is accepted
module order_table_snapshot_engine_core
  import otse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // control state
  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  phase_t              phase, phase_next;
  logic [2:0]          scan_ticker, scan_ticker_next;
  logic [SLOT_W-1:0]   scan_slot, scan_slot_next;
  logic [13:0]         snap_count, snap_count_next;
  logic [31:0]         last_seq, last_seq_next;

  // transaction held while the table read is in flight
  req_t                item;
  logic [ADDR_W-1:0]   addr;
  logic                item_in_range;

  // table ram
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  entry_t              ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  entry_t              rd_entry;

  // result of the transaction in flight
  rsp_t                res;
  logic                has_res;
  logic                look_we;
  entry_t              look_wdata;
  logic [2:0]          upd_status;

  logic                accept;
  logic                advance;
  logic                req_in_range;

  assign accept  = req_valid && !req_stall;
  // the lookup finishes only when the output register can take its result
  assign advance = (state == ST_LOOK) && !(rsp_valid && rsp_stall);
  assign req_stall = (state != ST_IDLE);

  assign req_in_range = (int'(req.ticker) < NUM_TICKERS) &&
                        (int'(req.order_id) < ORDERS_PER_TICKER);

  // read address: update slot, or the current slot of the scan walk
  always_comb begin
    if (req.func == FUNC_UPDATE) begin
      ram_raddr = req_in_range ?
                  ADDR_W'(int'(req.ticker) * ORDERS_PER_TICKER + int'(req.order_id)) :
                  '0;
    end else begin
      ram_raddr = ADDR_W'(int'(scan_ticker) * ORDERS_PER_TICKER + int'(scan_slot));
    end
  end

  assign ram_re    = accept;
  assign ram_we    = (state == ST_CLEAR) || (advance && look_we);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : addr;
  assign ram_wdata = (state == ST_CLEAR) ? entry_t'('0) : look_wdata;

  otse_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  // update and scan logic, evaluated on the table data read for the held transaction
  always_comb begin
    res              = '0;
    res.last_seq     = last_seq;
    has_res          = 1'b0;
    look_we          = 1'b0;
    look_wdata       = rd_entry;
    upd_status       = STAT_OK;
    last_seq_next    = last_seq;
    phase_next       = phase;
    scan_ticker_next = scan_ticker;
    scan_slot_next   = scan_slot;
    snap_count_next  = snap_count;

    if (item.func == FUNC_UPDATE) begin
      has_res  = 1'b1;
      res.kind = KIND_ACK;
      if (phase != PH_IDLE) begin
        // refused during a scan, nothing changes
        res.status = STAT_BUSY;
      end else begin
        unique case (item.update_type)
          UPD_ADD: begin
            priority if (!item_in_range) begin
              upd_status = STAT_MISSING;
            end else if (rd_entry.valid) begin
              upd_status = STAT_EXISTS;
            end else begin
              look_we                 = 1'b1;
              look_wdata.valid        = 1'b1;
              look_wdata.side         = item.side;
              look_wdata.price        = item.price;
              look_wdata.qty          = item.qty;
              look_wdata.priority_val = item.priority_req;
            end
          end
          UPD_MODIFY, UPD_CANCEL: begin
            priority if (!item_in_range || !rd_entry.valid) begin
              upd_status = STAT_MISSING;
            end else if (rd_entry.side != item.side) begin
              upd_status = STAT_SIDE;
            end else begin
              look_we = 1'b1;
              if (item.update_type == UPD_MODIFY) begin
                look_wdata.price = item.price;
                look_wdata.qty   = item.qty;
              end else begin
                look_wdata.valid = 1'b0;
              end
            end
          end
          default: begin
            // sequence tracking only
          end
        endcase
        // an order error outranks a sequence gap
        if (upd_status == STAT_OK && item.seq_num != last_seq + 32'd1) begin
          upd_status = STAT_GAP;
        end
        last_seq_next = item.seq_num;
        res.status    = upd_status;
        res.last_seq  = item.seq_num;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          has_res          = 1'b1;
          res.kind         = KIND_START;
          res.snap_index   = 14'd0;
          snap_count_next  = 14'd1;
          scan_ticker_next = '0;
          scan_slot_next   = '0;
          phase_next       = PH_CLEAR;
        end
        PH_CLEAR: begin
          has_res         = 1'b1;
          res.kind        = KIND_CLEAR;
          res.snap_index  = snap_count;
          res.out_ticker  = scan_ticker;
          snap_count_next = snap_count + 14'd1;
          scan_slot_next  = '0;
          phase_next      = PH_ORDERS;
        end
        PH_ORDERS: begin
          // empty slots give no result
          if (rd_entry.valid) begin
            has_res          = 1'b1;
            res.kind         = KIND_ENTRY;
            res.snap_index   = snap_count;
            res.out_ticker   = scan_ticker;
            res.out_order_id = 10'(scan_slot);
            res.out_side     = rd_entry.side;
            res.out_price    = rd_entry.price;
            res.out_qty      = rd_entry.qty;
            res.out_priority = rd_entry.priority_val;
            snap_count_next  = snap_count + 14'd1;
          end
          if (int'(scan_slot) + 1 >= ORDERS_PER_TICKER) begin
            scan_slot_next = '0;
            if (int'(scan_ticker) + 1 < NUM_TICKERS) begin
              scan_ticker_next = scan_ticker + 3'd1;
              phase_next       = PH_CLEAR;
            end else begin
              phase_next = PH_END;
            end
          end else begin
            scan_slot_next = scan_slot + SLOT_W'(1);
          end
        end
        default: begin
          has_res          = 1'b1;
          res.kind         = KIND_END;
          res.snap_index   = snap_count;
          snap_count_next  = snap_count + 14'd1;
          scan_ticker_next = '0;
          scan_slot_next   = '0;
          phase_next       = PH_IDLE;
        end
      endcase
    end
  end

  // sequencer: clearing pass, wait for a transaction, finish the lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(TABLE_SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (advance) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // held transaction and its table address
  always_ff @(posedge clk) begin
    if (accept) begin
      item          <= req;
      addr          <= ram_raddr;
      item_in_range <= req_in_range;
    end
  end

  // architectural state, committed when the lookup finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      scan_ticker <= '0;
      scan_slot   <= '0;
      snap_count  <= '0;
      last_seq    <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      scan_ticker <= scan_ticker_next;
      scan_slot   <= scan_slot_next;
      snap_count  <= snap_count_next;
      last_seq    <= last_seq_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance && has_res) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_res) begin
      rsp <= res;
    end
  end

  // the held transaction always reaches the lookup stage next
  a_accept_look : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOOK))
    else $error("accepted transaction did not move to lookup");

  // table writes only come from the clearing pass or a finished lookup
  a_write_src : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || advance))
    else $error("table write outside clear or lookup");

  // no result leaves while the table is still being cleared
  a_clear_quiet : assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !rsp_valid)
    else $error("result during clearing pass");

  // a pending result is never overwritten by a finishing lookup
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !advance)
    else $error("lookup finished over a stalled result");

endmodule
